// ----- hw/rtl/xnt_pkg.sv -----
// ----------------------------------------------------------------------------
// xnt_pkg
// Shared types, codes, the string table and the tag byte step of the XML
// node tokenizer.
// ----------------------------------------------------------------------------
package xnt_pkg;

    // Parser states
    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_PREFIX   = 5'd1;
    localparam logic [4:0] ST_TEXT     = 5'd2;
    localparam logic [4:0] ST_EL_PRE   = 5'd3;
    localparam logic [4:0] ST_EL_NAME  = 5'd4;
    localparam logic [4:0] ST_AT_WS    = 5'd5;
    localparam logic [4:0] ST_AT_NAME  = 5'd6;
    localparam logic [4:0] ST_AT_EQ    = 5'd7;
    localparam logic [4:0] ST_AT_VQ    = 5'd8;
    localparam logic [4:0] ST_AT_VAL   = 5'd9;
    localparam logic [4:0] ST_EL_REST  = 5'd10;
    localparam logic [4:0] ST_END_PRE  = 5'd11;
    localparam logic [4:0] ST_END_NAME = 5'd12;
    localparam logic [4:0] ST_END_REST = 5'd13;
    localparam logic [4:0] ST_COM_LEAD = 5'd14;
    localparam logic [4:0] ST_COM_BODY = 5'd15;
    localparam logic [4:0] ST_CDATA    = 5'd16;
    localparam logic [4:0] ST_PI       = 5'd17;

    // Node kinds
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_ELEMENT = 3'd1;
    localparam logic [2:0] KIND_END_EL  = 3'd2;
    localparam logic [2:0] KIND_TEXT    = 3'd3;
    localparam logic [2:0] KIND_COMMENT = 3'd4;
    localparam logic [2:0] KIND_CDATA   = 3'd5;
    localparam logic [2:0] KIND_PI      = 3'd6;

    // Byte roles
    localparam logic [2:0] ROLE_SKIP    = 3'd0;
    localparam logic [2:0] ROLE_MARKUP  = 3'd1;
    localparam logic [2:0] ROLE_NAME    = 3'd2;
    localparam logic [2:0] ROLE_ATNAME  = 3'd3;
    localparam logic [2:0] ROLE_ATVAL   = 3'd4;
    localparam logic [2:0] ROLE_CONTENT = 3'd5;
    localparam logic [2:0] ROLE_IGNORED = 3'd6;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;

    // Constant strings, selected by code
    localparam logic [2:0] SEL_CDATA     = 3'd0;  // <![CDATA[
    localparam logic [2:0] SEL_COMMENT   = 3'd1;  // <!--
    localparam logic [2:0] SEL_PI        = 3'd2;  // <?
    localparam logic [2:0] SEL_ENDTAG    = 3'd3;  // </
    localparam logic [2:0] SEL_END_COM   = 3'd4;  // -->
    localparam logic [2:0] SEL_END_CDATA = 3'd5;  // ]]>
    localparam logic [2:0] SEL_END_PI    = 3'd6;  // ?>

    localparam int STR_ROWS = 7;
    localparam int STR_LEN  = 9;

    localparam logic [7:0] STR_TAB [STR_ROWS][STR_LEN] = '{
        '{8'h3C, 8'h21, 8'h5B, 8'h43, 8'h44, 8'h41, 8'h54, 8'h41, 8'h5B},
        '{8'h3C, 8'h21, 8'h2D, 8'h2D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3C, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3C, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h2D, 8'h2D, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h5D, 8'h5D, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h3F, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    // Work for the back end: a run of string bytes, then an optional single byte
    typedef struct packed {
        logic [2:0] seq_sel;
        logic [3:0] seq_len;
        logic       seq_rep;      // every byte is the string's first byte
        logic [2:0] seq_kind;
        logic [2:0] seq_role_first;
        logic [2:0] seq_role_rest;
        logic       seq_begins;   // node begins on first string byte
        logic       seq_ends;     // node ends on last string byte
        logic       tail_valid;
        logic [7:0] tail_byte;
        logic [2:0] tail_kind;
        logic [2:0] tail_role;
        logic       tail_begins;
        logic       tail_ends;
        logic       tail_self;
        logic       doc_end;
    } cmd_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] role;
        logic       ends;
        logic       self_close;
        logic [4:0] next_state;
        logic       set_quote;
    } tag_res_t;

    function automatic logic is_sp(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
    endfunction

    // One element or end element byte
    function automatic tag_res_t tag_step(input logic [4:0] st, input logic [7:0] b,
                                          input logic [7:0] prev, input logic [7:0] quote);
        tag_res_t   r;
        logic [4:0] s;
        logic       sp;
        sp = is_sp(b);
        s  = st;
        r  = '0;
        r.next_state = st;
        // fall through to the state that really takes the byte
        if (s == ST_EL_PRE && (b == CH_SLASH || b == CH_GT))
            s = ST_AT_WS;
        if (s == ST_EL_NAME && (sp || b == CH_SLASH || b == CH_GT))
            s = ST_AT_WS;
        if (s == ST_AT_NAME && (b == CH_NUL || b == CH_GT || b == CH_SLASH))
            s = ST_EL_REST;
        if (s == ST_AT_EQ && !sp && b != CH_EQ)
            s = ST_EL_REST;
        if (s == ST_AT_VQ && !sp && b != CH_DQ && b != CH_SQ)
            s = ST_EL_REST;
        r.next_state = s;
        r.kind = KIND_ELEMENT;
        case (s)
            ST_EL_PRE:
            begin
                if (sp)
                    r.role = ROLE_SKIP;
                else
                begin
                    r.role = ROLE_NAME;
                    r.next_state = ST_EL_NAME;
                end
            end
            ST_EL_NAME:
            begin
                r.role = ROLE_NAME;
            end
            ST_AT_WS:
            begin
                if (sp)
                    r.role = ROLE_SKIP;
                else if (b == CH_GT)
                begin
                    r.role = ROLE_MARKUP;
                    r.ends = 1'b1;
                    r.self_close = (prev == CH_SLASH);
                    r.next_state = ST_IDLE;
                end
                else if (b == CH_SLASH || b == CH_NUL)
                begin
                    r.role = ROLE_MARKUP;
                    r.next_state = ST_EL_REST;
                end
                else if (b == CH_EQ)
                begin
                    r.role = ROLE_IGNORED;
                    r.next_state = ST_EL_REST;
                end
                else
                begin
                    r.role = ROLE_ATNAME;
                    r.next_state = ST_AT_NAME;
                end
            end
            ST_AT_NAME:
            begin
                if (sp)
                begin
                    r.role = ROLE_SKIP;
                    r.next_state = ST_AT_EQ;
                end
                else if (b == CH_EQ)
                begin
                    r.role = ROLE_MARKUP;
                    r.next_state = ST_AT_VQ;
                end
                else
                    r.role = ROLE_ATNAME;
            end
            ST_AT_EQ:
            begin
                if (sp)
                    r.role = ROLE_SKIP;
                else
                begin
                    r.role = ROLE_MARKUP;
                    r.next_state = ST_AT_VQ;
                end
            end
            ST_AT_VQ:
            begin
                if (sp)
                    r.role = ROLE_SKIP;
                else
                begin
                    r.role = ROLE_MARKUP;
                    r.set_quote = 1'b1;
                    r.next_state = ST_AT_VAL;
                end
            end
            ST_AT_VAL:
            begin
                if (b == quote)
                begin
                    r.role = ROLE_MARKUP;
                    r.next_state = ST_AT_WS;
                end
                else
                    r.role = ROLE_ATVAL;
            end
            ST_EL_REST:
            begin
                if (b == CH_GT)
                begin
                    r.role = ROLE_MARKUP;
                    r.ends = 1'b1;
                    r.self_close = (prev == CH_SLASH);
                    r.next_state = ST_IDLE;
                end
                else
                    r.role = ROLE_IGNORED;
            end
            ST_END_PRE, ST_END_NAME, ST_END_REST:
            begin
                r.kind = KIND_END_EL;
                if (b == CH_GT)
                begin
                    r.role = ROLE_MARKUP;
                    r.ends = 1'b1;
                    r.next_state = ST_IDLE;
                end
                else if (sp)
                begin
                    r.role = ROLE_SKIP;
                    if (s == ST_END_NAME)
                        r.next_state = ST_END_REST;
                end
                else if (b == CH_SLASH || s == ST_END_REST)
                begin
                    r.role = ROLE_IGNORED;
                    r.next_state = ST_END_REST;
                end
                else
                begin
                    r.role = ROLE_NAME;
                    r.next_state = ST_END_NAME;
                end
            end
            default:
            begin
                r.kind = KIND_NONE;
                r.role = ROLE_SKIP;
            end
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/xnt_front.sv -----
// ----------------------------------------------------------------------------
// xnt_front
// Takes one byte a cycle while the queue is not full, tracks the parse state and the prefix and
// terminator lookahead, and turns each byte into at most one work entry.
// ----------------------------------------------------------------------------
module xnt_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    output logic             q_push,
    output xnt_pkg::cmd_t    q_cmd,
    input  logic             q_full
);
    import xnt_pkg::*;

    logic [4:0] state_reg, state_next;
    logic [3:0] pend_reg, pend_next;     // bytes of an open '<' prefix
    logic       pcom_reg, pcom_next;     // prefix is on the comment path
    logic [7:0] quote_reg, quote_next;
    logic [1:0] match_reg, match_next;   // terminator bytes held
    logic [7:0] prev_reg, prev_next;

    logic       accept;
    logic [7:0] b;
    logic       sp;
    cmd_t       cmd;
    tag_res_t   tr_now, tr_fail;
    logic [2:0] csel;
    logic [2:0] ckind;
    logic [1:0] cplen;
    logic [1:0] ck;
    logic [7:0] cpk, cp0;
    logic [3:0] lastidx;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign sp       = is_sp(b);

    assign tr_now  = tag_step(state_reg, b, prev_reg, quote_reg);
    assign tr_fail = tag_step((pend_reg == 4'd1) ? ST_EL_PRE : ST_EL_NAME, b,
                              prev_reg, quote_reg);

    // terminator of the current body
    always_comb
    begin
        if (state_reg == ST_PI)
        begin
            csel = SEL_END_PI; ckind = KIND_PI; cplen = 2'd2;
        end
        else if (state_reg == ST_CDATA)
        begin
            csel = SEL_END_CDATA; ckind = KIND_CDATA; cplen = 2'd3;
        end
        else
        begin
            csel = SEL_END_COM; ckind = KIND_COMMENT; cplen = 2'd3;
        end
        ck  = (match_reg >= cplen) ? 2'd0 : match_reg;
        cpk = STR_TAB[csel][{2'b00, ck}];
        cp0 = STR_TAB[csel][0];
    end

    // byte decode
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        pend_next  = pend_reg;
        pcom_next  = pcom_reg;
        quote_next = quote_reg;
        match_next = match_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sp)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = KIND_NONE;
                    cmd.tail_role  = ROLE_SKIP;
                end
                else if (b == CH_LT)
                begin
                    pend_next  = 4'd1;
                    pcom_next  = 1'b0;
                    state_next = ST_PREFIX;
                end
                else
                begin
                    cmd.tail_valid  = 1'b1;
                    cmd.tail_kind   = KIND_TEXT;
                    cmd.tail_role   = ROLE_CONTENT;
                    cmd.tail_begins = 1'b1;
                    state_next      = ST_TEXT;
                end
            end
            ST_TEXT:
            begin
                if (b == CH_LT)
                begin
                    pend_next  = 4'd1;
                    pcom_next  = 1'b0;
                    state_next = ST_PREFIX;
                end
                else
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = KIND_TEXT;
                    cmd.tail_role  = ROLE_CONTENT;
                end
            end
            ST_PREFIX:
            begin
                cmd.seq_role_first = ROLE_MARKUP;
                cmd.seq_role_rest  = ROLE_MARKUP;
                cmd.seq_begins     = 1'b1;
                if (pend_reg == 4'd1 && b == CH_QUEST)
                begin
                    cmd.seq_sel  = SEL_PI;
                    cmd.seq_len  = 4'd2;
                    cmd.seq_kind = KIND_PI;
                    pend_next    = 4'd0;
                    match_next   = 2'd0;
                    state_next   = ST_PI;
                end
                else if (pend_reg == 4'd1 && b == CH_SLASH)
                begin
                    cmd.seq_sel  = SEL_ENDTAG;
                    cmd.seq_len  = 4'd2;
                    cmd.seq_kind = KIND_END_EL;
                    pend_next    = 4'd0;
                    match_next   = 2'd0;
                    state_next   = ST_END_PRE;
                end
                else if (!pcom_reg && b == STR_TAB[SEL_CDATA][pend_reg])
                begin
                    if (pend_reg == 4'(STR_LEN - 1))
                    begin
                        cmd.seq_sel  = SEL_CDATA;
                        cmd.seq_len  = 4'(STR_LEN);
                        cmd.seq_kind = KIND_CDATA;
                        pend_next    = 4'd0;
                        match_next   = 2'd0;
                        state_next   = ST_CDATA;
                    end
                    else
                        pend_next = pend_reg + 4'd1;
                end
                else if ((pend_reg <= 4'd2 || pcom_reg) && pend_reg <= 4'd3 &&
                         b == STR_TAB[SEL_COMMENT][pend_reg])
                begin
                    // only "<" or "<!" or a held "<!-" may go on to a comment
                    if (pend_reg == 4'd3)
                    begin
                        cmd.seq_sel  = SEL_COMMENT;
                        cmd.seq_len  = 4'd4;
                        cmd.seq_kind = KIND_COMMENT;
                        pend_next    = 4'd0;
                        match_next   = 2'd0;
                        state_next   = ST_COM_LEAD;
                    end
                    else
                    begin
                        pend_next = pend_reg + 4'd1;
                        pcom_next = 1'b1;
                    end
                end
                else
                begin
                    // no special prefix: held bytes open an element
                    cmd.seq_sel       = pcom_reg ? SEL_COMMENT : SEL_CDATA;
                    cmd.seq_len       = pend_reg;
                    cmd.seq_kind      = KIND_ELEMENT;
                    cmd.seq_role_rest = ROLE_NAME;
                    cmd.tail_valid    = 1'b1;
                    cmd.tail_kind     = tr_fail.kind;
                    cmd.tail_role     = tr_fail.role;
                    cmd.tail_ends     = tr_fail.ends;
                    pend_next         = 4'd0;
                    state_next        = tr_fail.next_state;
                end
            end
            ST_COM_LEAD, ST_COM_BODY, ST_CDATA, ST_PI:
            begin
                if (state_reg == ST_COM_LEAD && sp)
                begin
                    cmd.tail_valid = 1'b1;
                    cmd.tail_kind  = KIND_COMMENT;
                    cmd.tail_role  = ROLE_SKIP;
                end
                else
                begin
                    state_next = (state_reg == ST_COM_LEAD) ? ST_COM_BODY : state_reg;
                    cmd.seq_sel  = csel;
                    cmd.seq_kind = ckind;
                    if (b == cpk)
                    begin
                        if (ck + 2'd1 == cplen)
                        begin
                            cmd.seq_len        = {2'b00, cplen};
                            cmd.seq_role_first = ROLE_MARKUP;
                            cmd.seq_role_rest  = ROLE_MARKUP;
                            cmd.seq_ends       = 1'b1;
                            match_next         = 2'd0;
                            state_next         = ST_IDLE;
                        end
                        else
                            match_next = ck + 2'd1;
                    end
                    else if (ck != 2'd0 && b == cp0)
                    begin
                        cmd.tail_valid = 1'b1;
                        cmd.tail_kind  = ckind;
                        cmd.tail_role  = ROLE_CONTENT;
                    end
                    else
                    begin
                        // held terminator bytes were content after all
                        cmd.seq_len        = {2'b00, ck};
                        cmd.seq_role_first = ROLE_CONTENT;
                        cmd.seq_role_rest  = ROLE_CONTENT;
                        cmd.tail_valid     = 1'b1;
                        cmd.tail_kind      = ckind;
                        cmd.tail_role      = ROLE_CONTENT;
                        match_next         = 2'd0;
                    end
                end
            end
            default:
            begin
                cmd.tail_valid = 1'b1;
                cmd.tail_kind  = tr_now.kind;
                cmd.tail_role  = tr_now.role;
                cmd.tail_ends  = tr_now.ends;
                cmd.tail_self  = tr_now.self_close;
                if (tr_now.set_quote)
                    quote_next = b;
                state_next = tr_now.next_state;
            end
        endcase
        cmd.tail_byte = b;

        // end of document: flush whatever is held
        if (s_tlast)
        begin
            cmd.doc_end = 1'b1;
            if (state_next == ST_PREFIX && pend_next != 4'd0)
            begin
                cmd.seq_sel        = pcom_next ? SEL_COMMENT : SEL_CDATA;
                cmd.seq_len        = pend_next;
                cmd.seq_kind       = KIND_ELEMENT;
                cmd.seq_role_first = ROLE_MARKUP;
                cmd.seq_role_rest  = ROLE_NAME;
                cmd.seq_begins     = 1'b1;
            end
            else if (match_next != 2'd0 && (state_next == ST_COM_BODY ||
                     state_next == ST_CDATA || state_next == ST_PI))
            begin
                cmd.seq_sel        = csel;
                cmd.seq_kind       = ckind;
                cmd.seq_role_first = ROLE_CONTENT;
                cmd.seq_role_rest  = ROLE_CONTENT;
                if (cmd.tail_valid)
                begin
                    // repeated first terminator byte ahead of the held ones
                    cmd.seq_rep    = 1'b1;
                    cmd.seq_len    = {2'b00, match_next} + 4'd1;
                    cmd.tail_valid = 1'b0;
                end
                else
                    cmd.seq_len = {2'b00, match_next};
            end
        end

        // a string run ahead of the byte means the previous byte is no slash
        if (cmd.seq_len != 4'd0)
            cmd.tail_self = 1'b0;
    end

    // last byte handed out
    always_comb
    begin
        lastidx = cmd.seq_rep ? 4'd0 : (cmd.seq_len - 4'd1);
        if (cmd.tail_valid)
            prev_next = b;
        else if (cmd.seq_len != 4'd0)
            prev_next = STR_TAB[cmd.seq_sel][lastidx];
        else
            prev_next = prev_reg;
    end

    assign q_cmd  = cmd;
    assign q_push = accept && (cmd.tail_valid || cmd.seq_len != 4'd0);

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            pcom_reg  <= 1'b0;
            quote_reg <= '0;
            match_reg <= '0;
            prev_reg  <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                state_reg <= ST_IDLE;
                pend_reg  <= '0;
                pcom_reg  <= 1'b0;
                quote_reg <= '0;
                match_reg <= '0;
                prev_reg  <= '0;
            end
            else
            begin
                state_reg <= state_next;
                pend_reg  <= pend_next;
                pcom_reg  <= pcom_next;
                quote_reg <= quote_next;
                match_reg <= match_next;
                prev_reg  <= prev_next;
            end
        end
    end

endmodule

// ----- hw/rtl/xnt_queue.sv -----
// ----------------------------------------------------------------------------
// xnt_queue
// Short queue of work entries between the front and back ends.
// ----------------------------------------------------------------------------
module xnt_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  xnt_pkg::cmd_t    push_cmd,
    output logic             full,
    input  logic             pop,
    output xnt_pkg::cmd_t    head,
    output logic             valid
);
    import xnt_pkg::*;

    cmd_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wptr_reg, rptr_reg;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign head  = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_cmd;
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/xnt_back.sv -----
// ----------------------------------------------------------------------------
// xnt_back
// Expands each work entry into its result items, one a cycle while the
// receiver is ready, into an output register.
// ----------------------------------------------------------------------------
module xnt_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  xnt_pkg::cmd_t    q_cmd,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,   // out_byte, node_begins, node_ends,
                                        // self_closing, is_space, doc_end, pad
    output logic [5:0]       m_tuser,   // node_kind, byte_role
    output logic             m_tlast    // run_last
);
    import xnt_pkg::*;

    logic [3:0] pos_reg, pos_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [2:0] kind_reg, role_reg;
    logic       begins_reg, ends_reg, self_reg, space_reg, dend_reg, last_reg;

    logic       emit;
    logic       in_seq;
    logic       is_last;
    logic [3:0] total;
    logic [3:0] sidx;
    logic [7:0] r_byte;
    logic [2:0] r_kind, r_role;
    logic       r_begins, r_ends, r_self;

    assign emit    = q_valid && (!valid_reg || m_tready);
    assign total   = q_cmd.seq_len + {3'b000, q_cmd.tail_valid};
    assign in_seq  = (pos_reg < q_cmd.seq_len);
    assign is_last = (pos_reg + 4'd1 == total);
    assign sidx    = q_cmd.seq_rep ? 4'd0 : pos_reg;
    assign q_pop   = emit && is_last;

    // pick the current result
    always_comb
    begin
        if (in_seq)
        begin
            r_byte   = STR_TAB[q_cmd.seq_sel][sidx];
            r_kind   = q_cmd.seq_kind;
            r_role   = (pos_reg == 4'd0) ? q_cmd.seq_role_first : q_cmd.seq_role_rest;
            r_begins = q_cmd.seq_begins && (pos_reg == 4'd0);
            r_ends   = q_cmd.seq_ends && (pos_reg + 4'd1 == q_cmd.seq_len);
            r_self   = 1'b0;
        end
        else
        begin
            r_byte   = q_cmd.tail_byte;
            r_kind   = q_cmd.tail_kind;
            r_role   = q_cmd.tail_role;
            r_begins = q_cmd.tail_begins;
            r_ends   = q_cmd.tail_ends;
            r_self   = q_cmd.tail_self;
        end
        pos_next = is_last ? 4'd0 : pos_reg + 4'd1;
    end

    // position within the entry and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
                pos_reg <= pos_next;
            if (emit)
                valid_reg <= 1'b1;
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            byte_reg   <= r_byte;
            kind_reg   <= r_kind;
            role_reg   <= r_role;
            begins_reg <= r_begins;
            ends_reg   <= r_ends;
            self_reg   <= r_self;
            space_reg  <= is_sp(r_byte);
            dend_reg   <= is_last && q_cmd.doc_end;
            last_reg   <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, dend_reg, space_reg, self_reg, ends_reg, begins_reg, byte_reg};
    assign m_tuser  = {role_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- hw/rtl/xml_node_tokenizer_core.sv -----
// Path: a byte's results pass through the queue storage, then the output register;
// a '<' prefix or a terminator candidate is held until its next bytes decide it.
// Throughput: one byte accepted per cycle while the queue is not full; the back end
// sends one result per cycle while ready; a byte's up to 9 results hold the output in turn.
// Reset: rst_n is asynchronous, active low; parser state, queue and output clear.
// ----------------------------------------------------------------------------
// xml_node_tokenizer_core
// Byte-serial XML tokenizer: front end classifies, queue decouples, back end
// expands entries into tagged result items.
// ----------------------------------------------------------------------------
module xml_node_tokenizer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    input  logic        s_tlast,    // in_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // out_byte[7:0], node_begins, node_ends,
                                    // self_closing, is_space, doc_end, zero pad
    output logic [5:0]  m_tuser,    // node_kind[2:0], byte_role[5:3]
    output logic        m_tlast     // run_last
);
    import xnt_pkg::*;

    logic q_push, q_full, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    xnt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_cmd    (push_cmd),
        .q_full   (q_full)
    );

    xnt_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head_cmd),
        .valid    (q_valid)
    );

    xnt_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives XML byte streams into the node tokenizer and checks every tagged
// output item against a cycle-free predictor of the tokenizer.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import xnt_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic [2:0] kind;
        logic [2:0] role;
        logic       begins;
        logic       ends;
        logic       selfc;
        logic       sp;
        logic       dend;
        logic       rlast;
    } tok_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [5:0]  m_tuser;
    logic        m_tlast;

    xml_node_tokenizer_core dut
    (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Predictor state
    logic [4:0] p_state;
    logic [7:0] p_held [9];
    int         p_held_n;
    logic [7:0] p_quote;
    int         p_closer;
    logic [7:0] p_prev;
    tok_t       step_toks [$];
    tok_t       tok_queue [$];

    int   errors;
    int   sent;
    int   send_idle_pct;
    int   recv_stall_pct;
    bit   hold_recv;
    bit   long_hold_go;
    logic [7:0] stim_byte [$];
    logic       stim_last [$];

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    function automatic bit sp_byte(logic [7:0] b);
        return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
    endfunction

    function automatic void put_tok(logic [7:0] b, logic [2:0] k, logic [2:0] r,
                                    bit bg, bit en, bit sc);
        tok_t t;
        t = '0;
        t.b = b; t.kind = k; t.role = r; t.begins = bg; t.ends = en; t.selfc = sc;
        t.sp = sp_byte(b);
        step_toks.push_back(t);
        p_prev = b;
    endfunction

    function automatic void reset_tokenizer();
        p_state = ST_IDLE;
        p_held_n = 0;
        p_quote = 8'h00;
        p_closer = 0;
        p_prev = 8'h00;
    endfunction

    // One element or end element byte, with the fall-through between states
    function automatic void predict_tag(logic [7:0] b);
        bit sp;
        sp = sp_byte(b);
        forever
        begin
            case (p_state)
                ST_EL_PRE:
                begin
                    if (sp) begin put_tok(b, KIND_ELEMENT, ROLE_SKIP, 0, 0, 0); return; end
                    if (b == CH_SLASH || b == CH_GT) begin p_state = ST_AT_WS; continue; end
                    put_tok(b, KIND_ELEMENT, ROLE_NAME, 0, 0, 0);
                    p_state = ST_EL_NAME;
                    return;
                end
                ST_EL_NAME:
                begin
                    if (sp || b == CH_SLASH || b == CH_GT) begin p_state = ST_AT_WS; continue; end
                    put_tok(b, KIND_ELEMENT, ROLE_NAME, 0, 0, 0);
                    return;
                end
                ST_AT_WS:
                begin
                    if (sp) put_tok(b, KIND_ELEMENT, ROLE_SKIP, 0, 0, 0);
                    else if (b == CH_GT)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_MARKUP, 0, 1, p_prev == CH_SLASH);
                        p_state = ST_IDLE;
                    end
                    else if (b == CH_SLASH || b == CH_NUL)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_MARKUP, 0, 0, 0);
                        p_state = ST_EL_REST;
                    end
                    else if (b == CH_EQ)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_IGNORED, 0, 0, 0);
                        p_state = ST_EL_REST;
                    end
                    else
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_ATNAME, 0, 0, 0);
                        p_state = ST_AT_NAME;
                    end
                    return;
                end
                ST_AT_NAME:
                begin
                    if (sp)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_SKIP, 0, 0, 0);
                        p_state = ST_AT_EQ;
                        return;
                    end
                    if (b == CH_EQ)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_MARKUP, 0, 0, 0);
                        p_state = ST_AT_VQ;
                        return;
                    end
                    if (b == CH_NUL || b == CH_GT || b == CH_SLASH)
                    begin
                        p_state = ST_EL_REST;
                        continue;
                    end
                    put_tok(b, KIND_ELEMENT, ROLE_ATNAME, 0, 0, 0);
                    return;
                end
                ST_AT_EQ:
                begin
                    if (sp) begin put_tok(b, KIND_ELEMENT, ROLE_SKIP, 0, 0, 0); return; end
                    if (b == CH_EQ)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_MARKUP, 0, 0, 0);
                        p_state = ST_AT_VQ;
                        return;
                    end
                    p_state = ST_EL_REST;
                    continue;
                end
                ST_AT_VQ:
                begin
                    if (sp) begin put_tok(b, KIND_ELEMENT, ROLE_SKIP, 0, 0, 0); return; end
                    if (b == CH_DQ || b == CH_SQ)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_MARKUP, 0, 0, 0);
                        p_quote = b;
                        p_state = ST_AT_VAL;
                        return;
                    end
                    p_state = ST_EL_REST;
                    continue;
                end
                ST_AT_VAL:
                begin
                    if (b == p_quote)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_MARKUP, 0, 0, 0);
                        p_state = ST_AT_WS;
                    end
                    else
                        put_tok(b, KIND_ELEMENT, ROLE_ATVAL, 0, 0, 0);
                    return;
                end
                ST_EL_REST:
                begin
                    if (b == CH_GT)
                    begin
                        put_tok(b, KIND_ELEMENT, ROLE_MARKUP, 0, 1, p_prev == CH_SLASH);
                        p_state = ST_IDLE;
                    end
                    else
                        put_tok(b, KIND_ELEMENT, ROLE_IGNORED, 0, 0, 0);
                    return;
                end
                ST_END_PRE, ST_END_NAME, ST_END_REST:
                begin
                    if (b == CH_GT)
                    begin
                        put_tok(b, KIND_END_EL, ROLE_MARKUP, 0, 1, 0);
                        p_state = ST_IDLE;
                    end
                    else if (sp)
                    begin
                        put_tok(b, KIND_END_EL, ROLE_SKIP, 0, 0, 0);
                        if (p_state == ST_END_NAME)
                            p_state = ST_END_REST;
                    end
                    else if (b == CH_SLASH || p_state == ST_END_REST)
                    begin
                        put_tok(b, KIND_END_EL, ROLE_IGNORED, 0, 0, 0);
                        p_state = ST_END_REST;
                    end
                    else
                    begin
                        put_tok(b, KIND_END_EL, ROLE_NAME, 0, 0, 0);
                        p_state = ST_END_NAME;
                    end
                    return;
                end
                default:
                begin
                    put_tok(b, KIND_NONE, ROLE_SKIP, 0, 0, 0);
                    return;
                end
            endcase
        end
    endfunction

    function automatic logic [7:0] closer_char(logic [2:0] kind, int i);
        if (kind == KIND_COMMENT) return (i < 2) ? 8'h2D : CH_GT;
        if (kind == KIND_CDATA) return (i < 2) ? 8'h5D : CH_GT;
        return (i < 1) ? CH_QUEST : CH_GT;
    endfunction

    // Body byte of comment, cdata or instruction, watching for the closer
    function automatic void predict_body(logic [7:0] b, logic [2:0] kind);
        int plen;
        int k;
        plen = (kind == KIND_PI) ? 2 : 3;
        k = (p_closer >= plen) ? 0 : p_closer;
        if (b == closer_char(kind, k))
        begin
            k++;
            if (k == plen)
            begin
                for (int i = 0; i + 1 < plen; i++)
                    put_tok(closer_char(kind, i), kind, ROLE_MARKUP, 0, 0, 0);
                put_tok(b, kind, ROLE_MARKUP, 0, 1, 0);
                p_closer = 0;
                p_state = ST_IDLE;
                return;
            end
            p_closer = k;
            return;
        end
        if (k > 0 && b == closer_char(kind, 0))
        begin
            put_tok(closer_char(kind, 0), kind, ROLE_CONTENT, 0, 0, 0);
            return;
        end
        for (int i = 0; i < k; i++)
            put_tok(closer_char(kind, i), kind, ROLE_CONTENT, 0, 0, 0);
        p_closer = 0;
        put_tok(b, kind, ROLE_CONTENT, 0, 0, 0);
    endfunction

    function automatic void open_prefix(int n, logic [2:0] kind, logic [4:0] nxt);
        p_held_n = 0;
        p_closer = 0;
        for (int i = 0; i < n; i++)
            put_tok(p_held[i], kind, ROLE_MARKUP, i == 0, 0, 0);
        p_state = nxt;
    endfunction

    // Held '<' run that matched no special prefix: a plain element
    function automatic void prefix_as_element(int n);
        p_held_n = 0;
        if (n == 0) begin p_state = ST_IDLE; return; end
        put_tok(p_held[0], KIND_ELEMENT, ROLE_MARKUP, 1, 0, 0);
        p_state = ST_EL_PRE;
        for (int i = 1; i < n; i++)
            predict_tag(p_held[i]);
    endfunction

    function automatic void predict_prefix(logic [7:0] b);
        int n;
        bit ok;
        n = p_held_n;
        p_held[n] = b;
        n++;
        if (n == 2 && b == CH_QUEST) begin open_prefix(2, KIND_PI, ST_PI); return; end
        if (n == 2 && b == CH_SLASH) begin open_prefix(2, KIND_END_EL, ST_END_PRE); return; end
        ok = 1;
        for (int i = 0; i < n; i++)
            if (p_held[i] != STR_TAB[SEL_CDATA][i]) ok = 0;
        if (ok)
        begin
            if (n == 9) open_prefix(9, KIND_CDATA, ST_CDATA);
            else p_held_n = n;
            return;
        end
        ok = n <= 4;
        for (int i = 0; i < n && ok; i++)
            if (p_held[i] != STR_TAB[SEL_COMMENT][i]) ok = 0;
        if (ok)
        begin
            if (n == 4) open_prefix(4, KIND_COMMENT, ST_COM_LEAD);
            else p_held_n = n;
            return;
        end
        prefix_as_element(n);
    endfunction

    // Expected items for one accepted input byte
    function automatic void predict_byte(logic [7:0] b, bit last);
        logic [2:0] kind;
        int k;
        step_toks.delete();
        case (p_state)
            ST_IDLE:
                if (sp_byte(b)) put_tok(b, KIND_NONE, ROLE_SKIP, 0, 0, 0);
                else if (b == CH_LT) begin p_held[0] = b; p_held_n = 1; p_state = ST_PREFIX; end
                else begin put_tok(b, KIND_TEXT, ROLE_CONTENT, 1, 0, 0); p_state = ST_TEXT; end
            ST_TEXT:
                if (b == CH_LT) begin p_held[0] = b; p_held_n = 1; p_state = ST_PREFIX; end
                else put_tok(b, KIND_TEXT, ROLE_CONTENT, 0, 0, 0);
            ST_PREFIX:   predict_prefix(b);
            ST_COM_LEAD:
                if (sp_byte(b)) put_tok(b, KIND_COMMENT, ROLE_SKIP, 0, 0, 0);
                else begin p_state = ST_COM_BODY; predict_body(b, KIND_COMMENT); end
            ST_COM_BODY: predict_body(b, KIND_COMMENT);
            ST_CDATA:    predict_body(b, KIND_CDATA);
            ST_PI:       predict_body(b, KIND_PI);
            default:     predict_tag(b);
        endcase
        if (last)
        begin
            // flush held bytes at document end
            if (p_state == ST_PREFIX && p_held_n > 0)
                prefix_as_element(p_held_n);
            else if (p_closer > 0 &&
                     (p_state == ST_COM_BODY || p_state == ST_CDATA || p_state == ST_PI))
            begin
                kind = (p_state == ST_COM_BODY) ? KIND_COMMENT :
                       (p_state == ST_CDATA) ? KIND_CDATA : KIND_PI;
                k = (p_closer > 2) ? 2 : p_closer;
                for (int i = 0; i < k; i++)
                    put_tok(closer_char(kind, i), kind, ROLE_CONTENT, 0, 0, 0);
            end
            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].dend = 1'b1;
            reset_tokenizer();
        end
        if (step_toks.size() > 0) step_toks[step_toks.size() - 1].rlast = 1'b1;
        foreach (step_toks[i]) tok_queue.push_back(step_toks[i]);
    endfunction

    // Scoreboard: sample accepted outputs
    always @(posedge clk)
    begin
        tok_t got;
        tok_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '0;
            got.b = m_tdata[7:0]; got.begins = m_tdata[8]; got.ends = m_tdata[9];
            got.selfc = m_tdata[10]; got.sp = m_tdata[11]; got.dend = m_tdata[12];
            got.kind = m_tuser[2:0]; got.role = m_tuser[5:3]; got.rlast = m_tlast;
            if (tok_queue.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected item %h", got);
            end
            else
            begin
                want = tok_queue.pop_front();
                if (got != want || m_tdata[15:13] != 3'b000)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("item mismatch: expected %h got %h (tdata %h tuser %h)",
                                 want, got, m_tdata, m_tuser);
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here while the sender keeps offering
    initial
    begin
        hold_recv = 1'b0;
        wait (long_hold_go);
        hold_recv = 1'b1;
        repeat (200) @(posedge clk);
        hold_recv = 1'b0;
    end

    // Sender: drives the stimulus queue, predicting on acceptance
    always @(posedge clk)
    begin
        bit go;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predict_byte(s_tdata, s_tlast);
                sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                go = stim_byte.size() > 0 && $urandom_range(99) >= send_idle_pct;
                s_tvalid <= go;
                if (go)
                begin
                    s_tdata <= stim_byte.pop_front();
                    s_tlast <= stim_last.pop_front();
                end
            end
        end
    end

    task automatic add_text(string s, bit last_at_end);
        for (int i = 0; i < s.len(); i++)
        begin
            stim_byte.push_back(s[i]);
            stim_last.push_back(last_at_end && i == s.len() - 1);
        end
    endtask

    function automatic string pick(string opts [$]);
        return opts[$urandom_range(opts.size() - 1)];
    endfunction

    function automatic string rand_word();
        string w;
        string c;
        w = "";
        repeat ($urandom_range(1, 4))
        begin
            c = " ";
            c[0] = 8'h61 + $urandom_range(25);
            w = {w, c};
        end
        return w;
    endfunction

    // A random document fragment, mostly well formed
    function automatic string rand_piece();
        string c;
        case ($urandom_range(11))
            0: return {"<", rand_word(), ">"};
            1: return {"<", rand_word(), " ", rand_word(), "=\"", rand_word(), "\"/>"};
            2: return {"</", rand_word(), " >"};
            3: return {pick('{" ", "\t", "\r\n"}), rand_word()};
            4: return {"<!-- ", rand_word(), pick('{"-", "--", "->"}), " -->"};
            5: return {"<![CDATA[", rand_word(), pick('{"]", "]]", "]x"}), "]]>"};
            6: return {"<?", rand_word(), pick('{"?", " ?x"}), "?>"};
            7: return {"<", rand_word(), " ", rand_word(), " = '", rand_word(), "'>"};
            8: return {"<", rand_word(), pick('{" a b>", " =x>", " a=b>", " /x>"}), ""};
            9: return pick('{"<!-x", "<![CD", "<!", "< a>", "</>", "<>"});
            default:
            begin
                c = " ";
                c[0] = $urandom_range(255);
                return c;
            end
        endcase
    endfunction

    task automatic wait_drained();
        while (stim_byte.size() > 0 || s_tvalid || tok_queue.size() > 0)
            @(posedge clk);
    endtask

    // Directed documents
    string directed [] = '{
        " \t\r\nhi<a>",
        "<a/>",
        "<a b=\"1\" c='2'>x</a >",
        "<!-- c - -- --->",
        "<![CDATA[ ]x]]]>",
        "<? p ?x?>",
        "</ a/ b>",
        "<a / x>",
        "<a =x>",
        "<a b c>",
        "<![CD",
        "<!-- ab-",
        "<a"
    };

    initial
    begin
        string doc;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        long_hold_go = 1'b0;
        errors = 0;
        sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        reset_tokenizer();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: each document ends with last set
        foreach (directed[i])
            add_text(directed[i], 1);
        // NUL and 0xFF bytes in tags and text
        stim_byte.push_back(CH_LT); stim_last.push_back(0);
        stim_byte.push_back(8'h61); stim_last.push_back(0);
        stim_byte.push_back(8'h20); stim_last.push_back(0);
        stim_byte.push_back(CH_NUL); stim_last.push_back(0);
        stim_byte.push_back(CH_GT); stim_last.push_back(0);
        stim_byte.push_back(8'hFF); stim_last.push_back(1);
        wait_drained();

        // random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 61 : (ph == 3) ? 22 : 0;
            recv_stall_pct = (ph == 2) ? 61 : (ph == 3) ? 22 : 0;
            while (stim_byte.size() < 90)
            begin
                doc = rand_piece();
                add_text(doc, $urandom_range(9) == 0);
            end
            if (ph == 0)
                long_hold_go = 1'b1;
            wait_drained();
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && tok_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
